// ----- design/flip_segment_digit_controller_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Flip digit controller assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FLIP_SEGMENT_DIGIT_CONTROLLER_UNIT_ASSERT_SVH
`define FLIP_SEGMENT_DIGIT_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication: whenever cond holds, check holds too.
`define FSDC_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Next-cycle implication: whenever cond holds, check holds on the next clock.
`define FSDC_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

// ----- design/fsdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flip digit controller package
// Shared types, register indexes, constants and the digit segment table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsdc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ADDRESS      = 3'd0;
    localparam logic [2:0] CFG_SUBADDRESS   = 3'd1;
    localparam logic [2:0] CFG_START        = 3'd2;
    localparam logic [2:0] CFG_FULL_HOLD    = 3'd3;
    localparam logic [2:0] CFG_SEGMENT_HOLD = 3'd4;

    // Frame command bytes and value codes
    localparam logic [7:0] CMD_SHOW       = 8'h31;
    localparam logic [7:0] CMD_BLANK      = 8'h32;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] BLANK_VALUE    = 8'd101;
    localparam logic [7:0] POWERUP_VALUE  = 8'd102;
    localparam logic [7:0] REFRESH_FIRST  = 8'h01;
    localparam logic [6:0] SEG_ALL        = 7'h7F;

    // Operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_ADDRESS      = 8'd48;
    localparam logic [7:0] RST_SUBADDRESS   = 8'd51;
    localparam logic [7:0] RST_START        = 8'd240;
    localparam logic [7:0] RST_FULL_HOLD    = 8'd30;
    localparam logic [7:0] RST_SEGMENT_HOLD = 8'd30;

    typedef struct packed {
        logic [7:0] address_code;
        logic [7:0] subaddress_code;
        logic [7:0] start_code;
        logic [7:0] full_hold_ticks;
        logic [7:0] segment_hold_ticks;
    } fsdc_cfg_t;

    typedef struct packed {
        logic [6:0] set_coils;
        logic [6:0] clear_coils;
        logic [7:0] shown_value;
    } fsdc_result_t;

    // Segment pattern of a value; anything of ten or more is blank
    function automatic logic [6:0] digit_pattern(input logic [7:0] value);
        logic [6:0] pat;
        case (value)
            8'd0:    pat = 7'h77;
            8'd1:    pat = 7'h24;
            8'd2:    pat = 7'h5D;
            8'd3:    pat = 7'h6D;
            8'd4:    pat = 7'h2E;
            8'd5:    pat = 7'h6B;
            8'd6:    pat = 7'h7A;
            8'd7:    pat = 7'h25;
            8'd8:    pat = 7'h7F;
            8'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ----- design/fsdc_frame.sv -----
// ----------------------------------------------------------------------------
// Flip digit frame parser
// Collects start, address, command, data and value bytes; updates the wanted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdc_frame
    import fsdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  fsdc_cfg_t  cfg,
    output logic [7:0] wanted_value,
    output logic [7:0] wanted_next
);

    localparam logic [2:0] STEP_IDLE    = 3'd0;
    localparam logic [2:0] STEP_ADDRESS = 3'd1;
    localparam logic [2:0] STEP_COMMAND = 3'd2;
    localparam logic [2:0] STEP_DATA    = 3'd3;
    localparam logic [2:0] STEP_VALUE   = 3'd4;

    logic [2:0] step_reg, step_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] wanted_reg;

    always_comb
    begin
        step_next    = step_reg;
        address_next = address_reg;
        command_next = command_reg;
        data_next    = data_reg;
        wanted_next  = wanted_reg;
        if (byte_en)
        begin
            unique case (step_reg)
                STEP_ADDRESS:
                begin
                    address_next = rx_byte;
                    step_next    = STEP_COMMAND;
                end
                STEP_COMMAND:
                begin
                    command_next = rx_byte;
                    step_next    = STEP_DATA;
                end
                STEP_DATA:
                begin
                    data_next = rx_byte;
                    step_next = STEP_VALUE;
                end
                STEP_VALUE:
                begin
                    if (address_reg == cfg.address_code)
                    begin
                        if (command_reg == CMD_SHOW)
                        begin
                            if (data_reg == cfg.subaddress_code)
                                wanted_next = rx_byte - ASCII_ZERO;
                        end
                        else if (command_reg == CMD_BLANK)
                            wanted_next = BLANK_VALUE;
                    end
                    step_next = STEP_IDLE;
                end
                // idle and unused codes wait for the start byte
                default:
                    step_next = (rx_byte == cfg.start_code) ? STEP_ADDRESS : STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_IDLE;
            address_reg <= 8'd0;
            command_reg <= 8'd0;
            data_reg    <= 8'd0;
            wanted_reg  <= BLANK_VALUE;
        end
        else
        begin
            step_reg    <= step_next;
            address_reg <= address_next;
            command_reg <= command_next;
            data_reg    <= data_next;
            wanted_reg  <= wanted_next;
        end
    end

    assign wanted_value = wanted_reg;

endmodule

// ----- design/fsdc_drive.sv -----
// ----------------------------------------------------------------------------
// Flip digit coil sequencer
// Runs hold counting per tick, full drive on a value change, segment refresh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdc_drive
    import fsdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick_en,
    input  logic [7:0]   wanted_value,
    input  logic [7:0]   wanted_next,
    input  fsdc_cfg_t    cfg,
    output fsdc_result_t result_next
);

    `include "flip_segment_digit_controller_unit_assert.svh"

    logic [7:0] current_reg, current_next;
    logic [7:0] refresh_reg, refresh_next;
    logic [7:0] hold_reg, hold_next;
    logic       seg_hold_reg, seg_hold_next;
    logic [6:0] set_reg, set_next;
    logic [6:0] clear_reg, clear_next;
    logic [7:0] hold_left;
    logic [6:0] pattern_full;
    logic [6:0] pattern_cur;
    logic [6:0] seg_mask;

    assign pattern_full = digit_pattern(wanted_value);
    assign pattern_cur  = digit_pattern(current_reg);
    assign seg_mask     = refresh_reg[6:0];

    always_comb
    begin
        current_next  = current_reg;
        refresh_next  = refresh_reg;
        hold_next     = hold_reg;
        seg_hold_next = seg_hold_reg;
        set_next      = set_reg;
        clear_next    = clear_reg;
        hold_left     = 8'd0;
        if (hold_reg != 8'd0)
        begin
            // cut a segment hold short once the value is out of date
            if (seg_hold_reg && (current_reg != wanted_value))
                hold_left = 8'd0;
            else
                hold_left = hold_reg - 8'd1;
        end
        if (tick_en)
        begin
            hold_next = hold_left;
            if (hold_left == 8'd0)
            begin
                if (current_reg != wanted_value)
                begin
                    current_next  = wanted_value;
                    set_next      = pattern_full;
                    clear_next    = ~pattern_full & SEG_ALL;
                    hold_next     = cfg.full_hold_ticks;
                    seg_hold_next = 1'b0;
                end
                else
                begin
                    set_next      = pattern_cur & seg_mask;
                    clear_next    = ~pattern_cur & seg_mask;
                    refresh_next  = {refresh_reg[6:0], refresh_reg[7]};
                    hold_next     = cfg.segment_hold_ticks;
                    seg_hold_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg  <= POWERUP_VALUE;
            refresh_reg  <= REFRESH_FIRST;
            hold_reg     <= 8'd0;
            seg_hold_reg <= 1'b0;
            set_reg      <= 7'd0;
            clear_reg    <= 7'd0;
        end
        else
        begin
            current_reg  <= current_next;
            refresh_reg  <= refresh_next;
            hold_reg     <= hold_next;
            seg_hold_reg <= seg_hold_next;
            set_reg      <= set_next;
            clear_reg    <= clear_next;
        end
    end

    // the byte path changes only the wanted value, never the drive
    assign result_next.set_coils   = set_next;
    assign result_next.clear_coils = clear_next;
    assign result_next.shown_value = current_next;

    `FSDC_ASSERT_NOW(a_refresh_onehot, 1'b1, $onehot(refresh_reg),
        "refresh position lost its single bit")
    `FSDC_ASSERT_NOW(a_coils_disjoint, 1'b1, (set_reg & clear_reg) == 7'd0,
        "set and clear coil of one segment driven together")
    `FSDC_ASSERT_NEXT(a_byte_keeps_drive, !tick_en && (wanted_next == wanted_value),
        $stable(current_reg) && $stable(hold_reg),
        "drive state moved without a tick")

endmodule

// ----- design/flip_segment_digit_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Flip segment digit controller
// Byte frame parser and coil sequencer for one seven-segment flip digit.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid / in_stall) carries operation and rx_byte:
//   operation 0 feeds one received serial byte to the frame parser,
//   operation 1 is one 10 ms tick that advances the coil sequencer.
//   Every request yields exactly one result on the result channel
//   (out_valid / out_stall): set_coils, clear_coils and shown_value as they
//   stand after that request. Byte requests repeat the last tick's drive.
//   Throughput is one request per cycle while in_stall is low; the single
//   update pass between the state registers and the result register allows it.
//   When the receiver stalls, the result register holds and a skid register
//   takes one more request; in_stall rises only while the skid is full.
//   Reset clears both channels, returns the configuration registers to their
//   defaults, starts the parser waiting for a start byte and schedules a full
//   blank drive on the first tick.
//   Write configuration through cfg_write / cfg_index / cfg_data while idle;
//   indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flip_segment_digit_controller_unit
    import fsdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] set_coils,
    output logic [6:0] clear_coils,
    output logic [7:0] shown_value
);

    `include "flip_segment_digit_controller_unit_assert.svh"

    fsdc_cfg_t    cfg_reg;
    fsdc_result_t result_next;
    fsdc_result_t out_reg, out_next;
    fsdc_result_t skid_reg, skid_next;
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         in_accept;
    logic         out_fire;
    logic [7:0]   wanted_value;
    logic [7:0]   wanted_next;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_code       <= RST_ADDRESS;
            cfg_reg.subaddress_code    <= RST_SUBADDRESS;
            cfg_reg.start_code         <= RST_START;
            cfg_reg.full_hold_ticks    <= RST_FULL_HOLD;
            cfg_reg.segment_hold_ticks <= RST_SEGMENT_HOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ADDRESS:      cfg_reg.address_code       <= cfg_data;
                CFG_SUBADDRESS:   cfg_reg.subaddress_code    <= cfg_data;
                CFG_START:        cfg_reg.start_code         <= cfg_data;
                CFG_FULL_HOLD:    cfg_reg.full_hold_ticks    <= cfg_data;
                CFG_SEGMENT_HOLD: cfg_reg.segment_hold_ticks <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Frame parser: only byte requests move it
    fsdc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_en      (in_accept && (operation == OP_BYTE)),
        .rx_byte      (rx_byte),
        .cfg          (cfg_reg),
        .wanted_value (wanted_value),
        .wanted_next  (wanted_next)
    );

    // Coil sequencer: only tick requests move it
    fsdc_drive u_drive (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_en      (in_accept && (operation == OP_TICK)),
        .wanted_value (wanted_value),
        .wanted_next  (wanted_next),
        .cfg          (cfg_reg),
        .result_next  (result_next)
    );

    // Result register with one skid entry behind it
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid first; no request is taken this cycle
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result_next;
                out_valid_next = in_accept;
            end
        end
        else if (in_accept)
        begin
            // result register is held; park the new result
            skid_next       = result_next;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign set_coils   = out_reg.set_coils;
    assign clear_coils = out_reg.clear_coils;
    assign shown_value = out_reg.shown_value;

    `FSDC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held while result register empty")
    `FSDC_ASSERT_NEXT(a_stalled_request_parks, in_accept && out_valid_reg && out_stall,
        skid_valid_reg,
        "request taken under stall was not parked")

endmodule
